// ===== src/nei_pkg.sv =====
// Package for the NDVI/EVI pixel index block: widths, codes and shared types.
// Used by nei_front, nei_divider and ndvi_evi_pixel_index; depends on nothing.
`default_nettype none
package nei_pkg;

	localparam int BAND_W  = 16;
	localparam int MASK_W  = 8;
	localparam int SCALE_W = 32;
	localparam int PROD_W  = 48;             // band count times scale
	localparam int DIFF_W  = PROD_W + 1;     // N - R and N + R
	localparam int EDEN_W  = PROD_W + 6;     // signed EVI denominator
	localparam int PNUM_W  = DIFF_W + 13;    // signed numerator times 5000
	localparam int NUM_W   = 60;             // numerator magnitude
	localparam int DEN_W   = 53;             // denominator magnitude
	localparam int Q_W     = 17;             // quotient bits, one above int16 for saturation
	localparam int CMP_W   = DEN_W + Q_W;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 32;
	localparam int IN_W    = 56;
	localparam int OUT_W   = 32;

	localparam logic signed [BAND_W-1:0] FILL_CODE   = -16'sd9999;
	localparam logic [MASK_W-1:0]        MASK_NODATA = 8'hFF;
	localparam logic signed [BAND_W-1:0] SAT_MAX     = 16'sh7FFF;
	localparam logic signed [BAND_W-1:0] SAT_MIN     = -16'sh8000;

	typedef enum logic [IDX_W-1:0] {
		REG_SCALE_BLUE = 3'd0,
		REG_SCALE_RED  = 3'd1,
		REG_SCALE_NIR  = 3'd2,
		REG_FILL_RED   = 3'd3,
		REG_FILL_NIR   = 3'd4
	} nei_reg_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale_blue;
		logic [SCALE_W-1:0] scale_red;
		logic [SCALE_W-1:0] scale_nir;
		logic [BAND_W-1:0]  fill_red;
		logic [BAND_W-1:0]  fill_nir;
	} nei_cfg_t;

	// One division request: magnitudes, result sign and fill marker.
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             neg;
		logic             fill;
	} nei_div_req_t;

endpackage
`default_nettype wire

// ===== src/nei_front.sv =====
// Front end of the index pipeline: band scaling, fill checks and operand forming.
// Four register stages; depends on nei_pkg.
`default_nettype none
module nei_front
	import nei_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic [MASK_W-1:0]        cloud_mask,
	input  wire logic signed [BAND_W-1:0] blue_raw,
	input  wire logic signed [BAND_W-1:0] red_raw,
	input  wire logic signed [BAND_W-1:0] nir_raw,
	input  wire nei_cfg_t                 cfg,
	output logic                          req_valid,
	output nei_div_req_t                  ndvi_req,
	output nei_div_req_t                  evi_req
);

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [PROD_W-1:0] b_s1, r_s1, n_s1;
	logic                     bad_s1;
	logic signed [DIFF_W-1:0] diff_s2, sum_s2, sum_s3;
	logic signed [EDEN_W-1:0] eden_s2, eden_s3;
	logic                     nfill_s2, efill_s2, nfill_s3, efill_s3;
	logic signed [PNUM_W-1:0] nnum_s3, enum_s3;
	nei_div_req_t             ndvi_s4, evi_s4;

	// Valid bits advance with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: scale each band and check the mask and band fill values.
	always_ff @(posedge clk) begin
		if (en) begin
			b_s1   <= PROD_W'(blue_raw * $signed({1'b0, cfg.scale_blue}));
			r_s1   <= PROD_W'(red_raw * $signed({1'b0, cfg.scale_red}));
			n_s1   <= PROD_W'(nir_raw * $signed({1'b0, cfg.scale_nir}));
			bad_s1 <= (cloud_mask == MASK_NODATA) || (red_raw == cfg.fill_red) ||
				(nir_raw == cfg.fill_nir);
		end
	end

	// Stage 2: difference, sum, the doubled EVI denominator and non-positive band checks.
	always_ff @(posedge clk) begin
		if (en) begin
			diff_s2  <= DIFF_W'(n_s1) - DIFF_W'(r_s1);
			sum_s2   <= DIFF_W'(n_s1) + DIFF_W'(r_s1);
			eden_s2  <= EDEN_W'(n_s1) * EDEN_W'(2) + EDEN_W'(r_s1) * EDEN_W'(12) -
				EDEN_W'(b_s1) * EDEN_W'(15) + (EDEN_W'(1) <<< 33);
			nfill_s2 <= bad_s1 || (r_s1 <= 0) || (n_s1 <= 0);
			efill_s2 <= bad_s1 || (r_s1 <= 0) || (n_s1 <= 0) || (b_s1 <= 0);
		end
	end

	// Stage 3: numerators scaled by 1000 and 5000, and the zero EVI denominator check.
	always_ff @(posedge clk) begin
		if (en) begin
			nnum_s3  <= PNUM_W'(diff_s2) * PNUM_W'(1000);
			enum_s3  <= PNUM_W'(diff_s2) * PNUM_W'(5000);
			sum_s3   <= sum_s2;
			eden_s3  <= eden_s2;
			nfill_s3 <= nfill_s2;
			efill_s3 <= efill_s2 || (eden_s2 == 0);
		end
	end

	// Stage 4: magnitudes and signs for the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			ndvi_s4.num  <= NUM_W'(nnum_s3 < 0 ? -nnum_s3 : nnum_s3);
			ndvi_s4.den  <= DEN_W'(sum_s3);
			ndvi_s4.neg  <= nnum_s3 < 0;
			ndvi_s4.fill <= nfill_s3;
			evi_s4.num   <= NUM_W'(enum_s3 < 0 ? -enum_s3 : enum_s3);
			evi_s4.den   <= DEN_W'(eden_s3 < 0 ? -eden_s3 : eden_s3);
			evi_s4.neg   <= (enum_s3 < 0) != (eden_s3 < 0);
			evi_s4.fill  <= efill_s3;
		end
	end

	assign req_valid = v_s4;
	assign ndvi_req  = ndvi_s4;
	assign evi_req   = evi_s4;

endmodule
`default_nettype wire

// ===== src/nei_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sign, fill and
// int16 saturation in a final stage. Depends on nei_pkg.
`default_nettype none
module nei_divider
	import nei_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire nei_div_req_t         req,
	output logic                      out_valid,
	output logic signed [BAND_W-1:0]  result
);

	logic                 v_s   [Q_W];
	logic [NUM_W-1:0]     rem_s [Q_W];
	logic [DEN_W-1:0]     den_s [Q_W];
	logic [Q_W-1:0]       q_s   [Q_W];
	logic                 neg_s [Q_W];
	logic                 fill_s[Q_W];
	logic                 v_q;
	logic signed [BAND_W-1:0] res_q;
	logic [Q_W-1:0]       q_fin;

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic             pv, pneg, pfill, ge;
		logic [NUM_W-1:0] prem;
		logic [DEN_W-1:0] pden;
		logic [Q_W-1:0]   pq;
		logic [CMP_W-1:0] rem_x, dsh;

		if (i == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = req.num;
			assign pden  = req.den;
			assign pq    = '0;
			assign pneg  = req.neg;
			assign pfill = req.fill;
		end else begin : g_next
			assign pv    = v_s[i-1];
			assign prem  = rem_s[i-1];
			assign pden  = den_s[i-1];
			assign pq    = q_s[i-1];
			assign pneg  = neg_s[i-1];
			assign pfill = fill_s[i-1];
		end

		// Compare the remainder with the denominator shifted to this bit.
		assign rem_x = CMP_W'(prem);
		assign dsh   = CMP_W'(pden) << (Q_W - 1 - i);
		assign ge    = rem_x >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? NUM_W'(rem_x - dsh) : prem;
				den_s[i]  <= pden;
				q_s[i]    <= {pq[Q_W-2:0], ge};
				neg_s[i]  <= pneg;
				fill_s[i] <= pfill;
			end
		end
	end

	assign q_fin = q_s[Q_W-1];

	// Final stage: fill code, sign and saturation to int16.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s[Q_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fill_s[Q_W-1]) begin
				res_q <= FILL_CODE;
			end else if (neg_s[Q_W-1]) begin
				res_q <= (q_fin > Q_W'(32768)) ? SAT_MIN : BAND_W'(-$signed({1'b0, q_fin}));
			end else begin
				res_q <= (q_fin > Q_W'(32767)) ? SAT_MAX : BAND_W'(q_fin);
			end
		end
	end

	assign out_valid = v_q;
	assign result    = res_q;

endmodule
`default_nettype wire

// ===== src/ndvi_evi_pixel_index.sv =====
// Top level of the NDVI/EVI pixel index block: configuration registers,
// stall control and the front end and two dividers. Depends on nei_pkg,
// nei_front and nei_divider.
//
// One pixel enters on the s_axis channel per transaction and one result leaves
// on the m_axis channel. A pixel carries a cloud-mask byte and raw blue, red
// and near-infrared counts; the result carries NDVI*1000 and EVI*1000, each
// truncated toward zero, or the fill code -9999.
// Throughput is one pixel per clock while the output is not stalled. A pixel
// passes four front-end stages (scaling, sums, constant products, magnitudes),
// 17 divider stages, each resolving one quotient bit, and a sign/saturation stage.
// The whole pipeline advances together; when the receiver holds m_axis_tready
// low with a result waiting, every stage holds and s_axis_tready drops, so
// nothing is lost or repeated. Bubbles inside the pipeline stay in place while
// it is held.
// Reset clears all valid bits and loads the configuration reset values.
// Configuration is written through cfg_we, cfg_index and cfg_data and should be
// changed only while the pipeline is empty.
`default_nettype none
module ndvi_evi_pixel_index
	import nei_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// cloud_mask[7:0], blue_raw[23:8], red_raw[39:24], nir_raw[55:40]
	input  wire logic [IN_W-1:0]   s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// ndvi_scaled[15:0], evi_scaled[31:16]
	output logic [OUT_W-1:0]       m_axis_tdata,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	nei_cfg_t                 cfg_q;
	logic                     en;
	logic                     req_valid, nv, ev;
	nei_div_req_t             ndvi_req, evi_req;
	logic signed [BAND_W-1:0] ndvi, evi;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_blue <= 32'd429497;
			cfg_q.scale_red  <= 32'd429497;
			cfg_q.scale_nir  <= 32'd429497;
			cfg_q.fill_red   <= FILL_CODE;
			cfg_q.fill_nir   <= FILL_CODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE_BLUE: cfg_q.scale_blue <= cfg_data;
				REG_SCALE_RED:  cfg_q.scale_red  <= cfg_data;
				REG_SCALE_NIR:  cfg_q.scale_nir  <= cfg_data;
				REG_FILL_RED:   cfg_q.fill_red   <= cfg_data[BAND_W-1:0];
				REG_FILL_NIR:   cfg_q.fill_nir   <= cfg_data[BAND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The pipeline moves unless a finished result is waiting and the receiver is not ready.
	assign en            = !nv || m_axis_tready;
	assign s_axis_tready = en;

	nei_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_axis_tvalid),
		.cloud_mask (s_axis_tdata[7:0]),
		.blue_raw   (s_axis_tdata[23:8]),
		.red_raw    (s_axis_tdata[39:24]),
		.nir_raw    (s_axis_tdata[55:40]),
		.cfg        (cfg_q),
		.req_valid  (req_valid),
		.ndvi_req   (ndvi_req),
		.evi_req    (evi_req)
	);

	nei_divider u_div_ndvi (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.req       (ndvi_req),
		.out_valid (nv),
		.result    (ndvi)
	);

	nei_divider u_div_evi (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.req       (evi_req),
		.out_valid (ev),
		.result    (evi)
	);

	assign m_axis_tvalid = nv;
	assign m_axis_tdata  = {evi, ndvi};

	// Both dividers run in lockstep.
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n) nv == ev)
		else $error("divider valid bits differ");

	// NDVI stays within plus or minus 1000 unless it is fill.
	a_ndvi_range: assert property (@(posedge clk) disable iff (!arst_n)
		nv |-> (ndvi == FILL_CODE || (ndvi >= -16'sd1000 && ndvi <= 16'sd1000)))
		else $error("NDVI out of range");

	// A fill NDVI always comes with a fill EVI.
	a_fill_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(nv && ndvi == FILL_CODE) |-> (evi == FILL_CODE))
		else $error("NDVI fill without EVI fill");

endmodule
`default_nettype wire

// ===== test/tb_ndvi_evi_pixel_index.sv =====
// Testbench for ndvi_evi_pixel_index: directed and random pixels under random
// stalls on both stream sides, checked against a built-in integer predictor.
// Depends on nei_pkg and the block's RTL.
`default_nettype none
module tb_ndvi_evi_pixel_index;
	import nei_pkg::*;

	localparam int LATENCY = 22;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// Predictor copy of the configuration registers.
	logic [31:0] cur_scale_blue, cur_scale_red, cur_scale_nir;
	logic [15:0] cur_fill_red, cur_fill_nir;

	logic [OUT_W-1:0] expected_indices[$];
	int error_count = 0;
	int idle_cycles = 0;
	bit stalls_on = 1'b1;

	ndvi_evi_pixel_index DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Saturate a wide value to the int16 range.
	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return -16'sh8000;
		return v[15:0];
	endfunction

	// Compute NDVI*1000 and EVI*1000 for one pixel with the current registers.
	function automatic logic [OUT_W-1:0] vegetation_indices(input logic [7:0] mask,
			input logic [15:0] blue, input logic [15:0] red, input logic [15:0] nir);
		logic signed [15:0] ndvi, evi;
		longint b, r, n, diff, den;
		ndvi = FILL_CODE;
		evi = FILL_CODE;
		if (mask != MASK_NODATA && red != cur_fill_red && nir != cur_fill_nir) begin
			b = longint'($signed(blue)) * longint'({32'd0, cur_scale_blue});
			r = longint'($signed(red)) * longint'({32'd0, cur_scale_red});
			n = longint'($signed(nir)) * longint'({32'd0, cur_scale_nir});
			if (r > 0 && n > 0) begin
				diff = n - r;
				ndvi = clamp16((diff * 1000) / (n + r));
				if (b > 0) begin
					den = 2 * n + 12 * r - 15 * b + (64'sd1 <<< 33);
					if (den != 0) evi = clamp16((diff * 5000) / den);
				end
			end
		end
		return {evi, ndvi};
	endfunction

	// Random idle burst while stalls are enabled; the input goes idle first.
	task automatic maybe_idle();
		if (stalls_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
	endtask

	// Send one pixel and record its expected result. The valid stays high so that
	// the next pixel can follow back to back unless an idle burst comes between.
	task automatic send_pixel(input logic [7:0] mask, input logic [15:0] blue,
			input logic [15:0] red, input logic [15:0] nir);
		maybe_idle();
		expected_indices.push_back(vegetation_indices(mask, blue, red, nir));
		s_axis_tdata <= {nir, red, blue, mask};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Wait for the pipeline to drain, then write one register.
	task automatic write_reg(input nei_reg_t idx, input logic [31:0] value);
		s_axis_tvalid <= 1'b0;
		while (expected_indices.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SCALE_BLUE: cur_scale_blue = value;
			REG_SCALE_RED: cur_scale_red = value;
			REG_SCALE_NIR: cur_scale_nir = value;
			REG_FILL_RED: cur_fill_red = value[15:0];
			default: cur_fill_nir = value[15:0];
		endcase
	endtask

	// Receiver side: random back-pressure.
	always @(negedge clk) begin
		if (stalls_on && $urandom_range(0, 15) == 0) begin
			m_axis_tready <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		m_axis_tready <= 1'b1;
	end

	// Check each result transaction against the oldest expectation.
	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_indices.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
				error_count++;
			end else begin
				want = expected_indices.pop_front();
				if (m_axis_tdata[15:0] !== want[15:0]) begin
					$display("%0t: ndvi_scaled expected %0d actual %0d", $time,
						$signed(want[15:0]), $signed(m_axis_tdata[15:0]));
					error_count++;
				end
				if (m_axis_tdata[31:16] !== want[31:16]) begin
					$display("%0t: evi_scaled expected %0d actual %0d", $time,
						$signed(want[31:16]), $signed(m_axis_tdata[31:16]));
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_ndvi_evi_pixel_index: errors");
			$finish;
		end
	end

	// Directed corners: extremes, fills, no-data mask and non-positive bands.
	task automatic test_directed();
		send_pixel(8'd0, 16'd500, 16'd1000, 16'd3000);
		send_pixel(8'hFF, 16'd500, 16'd1000, 16'd3000);
		send_pixel(8'd0, 16'd500, FILL_CODE, 16'd3000);
		send_pixel(8'd0, 16'd500, 16'd1000, FILL_CODE);
		send_pixel(8'd0, 16'd500, 16'd0, 16'd3000);
		send_pixel(8'd0, 16'd500, 16'd1000, 16'hFFFF);
		send_pixel(8'd0, 16'd0, 16'd1000, 16'd3000);
		send_pixel(8'd0, 16'h8000, 16'd1000, 16'd3000);
		send_pixel(8'd254, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_pixel(8'd0, 16'd1, 16'd1, 16'h7FFF);
		send_pixel(8'd0, 16'h7FFF, 16'd1, 16'h7FFF);
		send_pixel(8'd0, 16'h8000, 16'h8000, 16'h8000);
		send_pixel(8'd0, 16'd1, 16'h7FFF, 16'd1);
	endtask

	// Tune the scales so the EVI denominator gets near zero and EVI saturates, then try zero scales and new fill values.
	task automatic test_evi_extremes();
		write_reg(REG_SCALE_BLUE, 32'hFFFF_FFFF);
		write_reg(REG_SCALE_RED, 32'd1);
		write_reg(REG_SCALE_NIR, 32'd1);
		send_pixel(8'd0, 16'd1, 16'd1, 16'd2);
		send_pixel(8'd0, 16'd2, 16'd1, 16'd3000);
		// 15*blue*scale exceeds 2^33 here, giving a negative denominator.
		send_pixel(8'd0, 16'h7FFF, 16'd5, 16'd9);
		write_reg(REG_SCALE_BLUE, 32'd0);
		send_pixel(8'd0, 16'd100, 16'd1, 16'd2);
		write_reg(REG_SCALE_RED, 32'd0);
		send_pixel(8'd0, 16'd100, 16'd10, 16'd20);
		write_reg(REG_SCALE_NIR, 32'hFFFF_FFFF);
		write_reg(REG_SCALE_RED, 32'hFFFF_FFFF);
		send_pixel(8'd0, 16'd100, 16'h7FFF, 16'h7FFF);
		write_reg(REG_FILL_RED, 32'h0000_7FFF);
		write_reg(REG_FILL_NIR, 32'h0000_8000);
		send_pixel(8'd0, 16'd100, 16'h7FFF, 16'd5);
		send_pixel(8'd0, 16'd100, 16'd5, 16'h8000);
	endtask

	// Random pixels under a chosen register setting.
	task automatic test_random(input int count, input bit use_fills);
		logic [7:0] mask;
		logic [15:0] blue, red, nir;
		for (int i = 0; i < count; i++) begin
			mask = ($urandom_range(0, 15) == 0) ? MASK_NODATA : 8'($urandom);
			blue = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 4000));
			red = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(1, 6000));
			nir = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(1, 10000));
			if (use_fills && $urandom_range(0, 9) == 0) red = cur_fill_red;
			if (use_fills && $urandom_range(0, 9) == 0) nir = cur_fill_nir;
			send_pixel(mask, blue, red, nir);
		end
	endtask

	// Random registers then random pixels.
	task automatic test_random_config();
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_SCALE_BLUE, $urandom);
			write_reg(REG_SCALE_RED, $urandom);
			write_reg(REG_SCALE_NIR, $urandom);
			write_reg(REG_FILL_RED, $urandom_range(0, 65535));
			write_reg(REG_FILL_NIR, $urandom_range(0, 65535));
			test_random(50, 1'b1);
		end
	endtask

	initial begin
		cur_scale_blue = 32'd429497;
		cur_scale_red = 32'd429497;
		cur_scale_nir = 32'd429497;
		cur_fill_red = FILL_CODE;
		cur_fill_nir = FILL_CODE;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(100, 1'b1);
		test_evi_extremes();
		test_random_config();
		write_reg(REG_SCALE_BLUE, 32'd429497);
		write_reg(REG_SCALE_RED, 32'd429497);
		write_reg(REG_SCALE_NIR, 32'd429497);
		write_reg(REG_FILL_RED, 32'h0000_D8F1);
		write_reg(REG_FILL_NIR, 32'h0000_D8F1);
		stalls_on = 1'b0;
		test_random(80, 1'b1);
		s_axis_tvalid <= 1'b0;
		while (expected_indices.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		if (error_count == 0)
			$display("tb_ndvi_evi_pixel_index: clean");
		else
			$display("tb_ndvi_evi_pixel_index: errors");
		$finish;
	end

endmodule
`default_nettype wire
